// ===== src/extended_euclid_bezout_unit_defines.svh =====
// Assertion macros for the extended Euclid Bezout unit.
`ifndef EXTENDED_EUCLID_BEZOUT_UNIT_DEFINES_SVH
`define EXTENDED_EUCLID_BEZOUT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define EEB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define EEB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define EEB_ASSERT_IMP(label, ante, cons)
`define EEB_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== src/eeb_pkg.sv =====
// Shared types for the extended Euclid Bezout unit.
package eeb_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FWD,
    ST_BACK_RD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_UPD,
    ST_DONE
  } eeb_state_t;

endpackage

// ===== src/extended_euclid_bezout_unit.sv =====
// Extended Euclid unit: gcd by truncating division plus Bezout coefficients.
//
// Usage:
//   Drive in_value_n / in_value_k and pulse start while busy is low; the
//   transaction is taken on that edge and busy stays high until the result
//   has been shown. The result appears on out_divisor, out_coef_n,
//   out_coef_k and out_div_zero for exactly one cycle with out_valid high.
//   The receiver cannot stall; it must capture the result in that cycle.
// Operation:
//   Each Euclid step runs on one shared radix-2 divider and then logs its
//   quotient. The back pass runs a quotient memory read, two half
//   multiplies and an update for each earlier step. A zero in_value_k
//   gives div_zero with zero fields and skips the division.
//   One transaction is in flight at a time.
// Reset:
//   rst_n is synchronous, active low; it returns the sequencer to idle and
//   drops any transaction in progress. No memory clearing is needed.
`include "extended_euclid_bezout_unit_defines.svh"

module extended_euclid_bezout_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_value_n,
  input  logic signed [DATA_WIDTH-1:0] in_value_k,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_divisor,
  output logic signed [DATA_WIDTH+1:0] out_coef_n,
  output logic signed [DATA_WIDTH+1:0] out_coef_k,
  output logic                         out_div_zero
);

  localparam int W         = DATA_WIDTH;
  localparam int CW        = DATA_WIDTH + 2;
  localparam int MAX_STEPS = 2 * DATA_WIDTH + 8;
  localparam int DEPTH_W   = $clog2(MAX_STEPS + 1);
  localparam int ADDR_W    = $clog2(MAX_STEPS);
  localparam int CNT_W     = $clog2(DATA_WIDTH);
  localparam int LO_W      = (CW + 1) / 2;
  localparam int HI_W      = CW - LO_W;

  eeb_pkg::eeb_state_t state_r, state_nxt;

  logic [W-1:0]       rem_r, rem_nxt;
  logic [W-1:0]       quo_r, quo_nxt;
  logic [W-1:0]       dvs_r, dvs_nxt;
  logic               sn_r, sn_nxt;
  logic               sk_r, sk_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DEPTH_W-1:0] step_r, step_nxt;
  logic [CW-1:0]      a_r, a_nxt;
  logic [CW-1:0]      b_r, b_nxt;
  logic [CW-1:0]      prod_r, prod_nxt;
  logic [W-1:0]       gcd_r, gcd_nxt;
  logic               dz_r, dz_nxt;
  logic [W:0]         q_rd_r;

  logic [W:0]         quot_mem [MAX_STEPS];

  logic               accept;
  logic [W-1:0]       abs_n;
  logic [W-1:0]       abs_k;
  logic [W:0]         shifted;
  logic [W:0]         diff;
  logic [W:0]         q_mag;
  logic [W:0]         q_val;
  logic               last_step;
  logic [CW-1:0]      qx;
  logic [CW-1:0]      mul_lo;
  logic [HI_W-1:0]    mul_hi;

  assign accept  = start && !busy;
  assign abs_n   = in_value_n[W-1] ? ({W{1'b0}} - $unsigned(in_value_n)) : $unsigned(in_value_n);
  assign abs_k   = in_value_k[W-1] ? ({W{1'b0}} - $unsigned(in_value_k)) : $unsigned(in_value_k);
  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign q_mag   = {1'b0, quo_r};
  assign q_val   = (sn_r ^ sk_r) ? ({(W+1){1'b0}} - q_mag) : q_mag;
  assign last_step = (rem_r == '0) || (step_r == DEPTH_W'(MAX_STEPS - 1));
  assign qx      = {q_rd_r[W], q_rd_r};
  assign mul_lo  = b_r * {{HI_W{1'b0}}, qx[LO_W-1:0]};
  assign mul_hi  = b_r[HI_W-1:0] * qx[CW-1:LO_W];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      eeb_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_value_k == '0) ? eeb_pkg::ST_DONE : eeb_pkg::ST_DIV;
        end
      end
      eeb_pkg::ST_DIV: begin
        if (cnt_r == CNT_W'(W - 1)) begin
          state_nxt = eeb_pkg::ST_FWD;
        end
      end
      eeb_pkg::ST_FWD: begin
        if (!last_step) begin
          state_nxt = eeb_pkg::ST_DIV;
        end else if (step_r == '0) begin
          state_nxt = eeb_pkg::ST_DONE;
        end else begin
          state_nxt = eeb_pkg::ST_BACK_RD;
        end
      end
      eeb_pkg::ST_BACK_RD: state_nxt = eeb_pkg::ST_MUL_LO;
      eeb_pkg::ST_MUL_LO:  state_nxt = eeb_pkg::ST_MUL_HI;
      eeb_pkg::ST_MUL_HI:  state_nxt = eeb_pkg::ST_UPD;
      eeb_pkg::ST_UPD: begin
        state_nxt = (step_r == '0) ? eeb_pkg::ST_DONE : eeb_pkg::ST_BACK_RD;
      end
      eeb_pkg::ST_DONE: state_nxt = eeb_pkg::ST_IDLE;
      default: state_nxt = eeb_pkg::ST_IDLE;
    endcase
  end

  // Datapath
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    sn_nxt   = sn_r;
    sk_nxt   = sk_r;
    cnt_nxt  = cnt_r;
    step_nxt = step_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    prod_nxt = prod_r;
    gcd_nxt  = gcd_r;
    dz_nxt   = dz_r;
    case (state_r)
      eeb_pkg::ST_IDLE: begin
        if (accept) begin
          rem_nxt  = '0;
          quo_nxt  = abs_n;
          dvs_nxt  = abs_k;
          sn_nxt   = in_value_n[W-1];
          sk_nxt   = in_value_k[W-1];
          cnt_nxt  = '0;
          step_nxt = '0;
          dz_nxt   = (in_value_k == '0);
          a_nxt    = '0;
          b_nxt    = '0;
          gcd_nxt  = '0;
        end
      end
      eeb_pkg::ST_DIV: begin
        if (!diff[W]) begin
          rem_nxt = diff[W-1:0];
        end else begin
          rem_nxt = shifted[W-1:0];
        end
        quo_nxt = {quo_r[W-2:0], ~diff[W]};
        cnt_nxt = cnt_r + 1'b1;
      end
      eeb_pkg::ST_FWD: begin
        if (!last_step) begin
          quo_nxt  = dvs_r;
          dvs_nxt  = rem_r;
          rem_nxt  = '0;
          sn_nxt   = sk_r;
          sk_nxt   = sn_r;
          cnt_nxt  = '0;
          step_nxt = step_r + 1'b1;
        end else begin
          a_nxt   = CW'(1);
          b_nxt   = CW'(1) - {q_val[W], q_val};
          gcd_nxt = sk_r ? ({W{1'b0}} - dvs_r) : dvs_r;
          if (step_r != '0) begin
            step_nxt = step_r - 1'b1;
          end
        end
      end
      eeb_pkg::ST_MUL_LO: prod_nxt = mul_lo;
      eeb_pkg::ST_MUL_HI: prod_nxt = prod_r + {mul_hi, {LO_W{1'b0}}};
      eeb_pkg::ST_UPD: begin
        a_nxt = b_r;
        b_nxt = a_r - prod_r;
        if (step_r != '0) begin
          step_nxt = step_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    busy      = (state_r != eeb_pkg::ST_IDLE);
    out_valid = (state_r == eeb_pkg::ST_DONE);
  end

  assign out_divisor  = gcd_r;
  assign out_coef_n   = a_r;
  assign out_coef_k   = b_r;
  assign out_div_zero = dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eeb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    sn_r   <= sn_nxt;
    sk_r   <= sk_nxt;
    cnt_r  <= cnt_nxt;
    step_r <= step_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    gcd_r  <= gcd_nxt;
    dz_r   <= dz_nxt;
  end

  // Quotient log: written once per forward step, read back in reverse order
  always_ff @(posedge clk) begin
    if (state_r == eeb_pkg::ST_FWD) begin
      quot_mem[step_r[ADDR_W-1:0]] <= q_val;
    end
    q_rd_r <= quot_mem[step_r[ADDR_W-1:0]];
  end

  `EEB_ASSERT_NXT(a_strobe_single, out_valid, !out_valid)
  `EEB_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `EEB_ASSERT_IMP(a_dz_zero_fields, out_valid && out_div_zero, (out_divisor == '0) && (out_coef_n == '0) && (out_coef_k == '0))
  `EEB_ASSERT_IMP(a_div_nonzero, state_r == eeb_pkg::ST_DIV, (dvs_r != '0) && (rem_r < dvs_r))
  `EEB_ASSERT_IMP(a_step_bound, busy, step_r < DEPTH_W'(MAX_STEPS))

endmodule

// ===== test/extended_euclid_bezout_unit_checker.sv =====
// Checker for the extended Euclid unit: predicts gcd and Bezout coefficients and compares results.
module extended_euclid_bezout_unit_checker #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_value_n,
  input  logic signed [DATA_WIDTH-1:0] in_value_k,
  input  logic                         out_valid,
  input  logic signed [DATA_WIDTH-1:0] out_divisor,
  input  logic signed [DATA_WIDTH+1:0] out_coef_n,
  input  logic signed [DATA_WIDTH+1:0] out_coef_k,
  input  logic                         out_div_zero,
  output int                           fail_count,
  output int                           outstanding,
  output int                           checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxSteps = 2 * DATA_WIDTH + 8;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] divisor;
    logic signed [DATA_WIDTH+1:0] coef_n;
    logic signed [DATA_WIDTH+1:0] coef_k;
    logic                         div_zero;
  } bezout_t;

  bezout_t pending_bezout[$];
  int      fails = 0;
  int      checks = 0;

  // Truncating division chain, then coefficients rebuilt from the last step, modulo 2^64.
  function automatic bezout_t bezout_of(input logic signed [DATA_WIDTH-1:0] n_in,
                                        input logic signed [DATA_WIDTH-1:0] k_in);
    longint    n;
    longint    k;
    longint    q;
    longint    r;
    longint    quot [MaxSteps];
    int        depth;
    int        i;
    bit        done;
    bit [63:0] a;
    bit [63:0] b;
    bit [63:0] t;
    bit [63:0] g;
    bezout_t   res;
    res.divisor  = '0;
    res.coef_n   = '0;
    res.coef_k   = '0;
    res.div_zero = 1'b0;
    if (k_in == 0) begin
      res.div_zero = 1'b1;
      return res;
    end
    n     = n_in;
    k     = k_in;
    depth = 0;
    done  = 1'b0;
    while (!done) begin
      q = n / k;
      r = n % k;
      quot[depth] = q;
      depth++;
      if (r == 0 || depth >= MaxSteps) begin
        done = 1'b1;
      end else begin
        n = k;
        k = r;
      end
    end
    a = 64'd1;
    b = 64'd1 - 64'(quot[depth-1]);
    for (i = depth - 2; i >= 0; i--) begin
      t = a - b * 64'(quot[i]);
      a = b;
      b = t;
    end
    g            = 64'(k);
    res.divisor  = g[DATA_WIDTH-1:0];
    res.coef_n   = a[DATA_WIDTH+1:0];
    res.coef_k   = b[DATA_WIDTH+1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    bezout_t want;
    if (!rst_n) begin
      pending_bezout.delete();
    end else begin
      if (out_valid) begin
        if (pending_bezout.size() == 0) begin
          fails++;
          $error("result transaction with none outstanding: divisor %0d", out_divisor);
        end else begin
          want = pending_bezout.pop_front();
          checks++;
          if (out_divisor !== want.divisor) begin
            fails++;
            $error("divisor: expected %0d, got %0d", want.divisor, out_divisor);
          end
          if (out_coef_n !== want.coef_n) begin
            fails++;
            $error("coef_n: expected %0d, got %0d", want.coef_n, out_coef_n);
          end
          if (out_coef_k !== want.coef_k) begin
            fails++;
            $error("coef_k: expected %0d, got %0d", want.coef_k, out_coef_k);
          end
          if (out_div_zero !== want.div_zero) begin
            fails++;
            $error("div_zero: expected %0b, got %0b", want.div_zero, out_div_zero);
          end
        end
      end
      if (start && !busy) begin
        pending_bezout.push_back(bezout_of(in_value_n, in_value_k));
      end
    end
    fail_count    <= fails;
    checked_count <= checks;
    outstanding   <= pending_bezout.size();
  end

endmodule

// ===== test/extended_euclid_bezout_unit_tb.sv =====
// Testbench top for the extended Euclid unit: reset, operand stimulus and verdict.
module extended_euclid_bezout_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     DW         = 32;
  localparam int     Items      = 400;
  localparam longint CycleLimit = 4_000_000;
  localparam int     NumDirected = 24;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic signed [DW-1:0] in_value_n;
  logic signed [DW-1:0] in_value_k;
  logic                 out_valid;
  logic signed [DW-1:0] out_divisor;
  logic signed [DW+1:0] out_coef_n;
  logic signed [DW+1:0] out_coef_k;
  logic                 out_div_zero;

  int     fail_count;
  int     outstanding;
  int     checked_count;
  int     issued = 0;
  int     zero_k_count = 0;
  longint cycles = 0;

  // operand pairs: zero k, zero n, sign extremes, Fibonacci chains, plain cases
  logic signed [DW-1:0] directed_n [NumDirected] = '{
    32'sd5, 32'sh8000_0000, 32'sd0, 32'sd0, 32'sd0, 32'sd7, 32'sd7, 32'sd1,
    -32'sd1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
    32'sh8000_0000, 32'sh7fff_ffff, 32'sd1836311903, -32'sd1836311903,
    32'sd1134903170, 32'sd12, -32'sd12, 32'sd240, 32'sh5555_5555,
    32'shaaaa_aaaa, 32'sd17
  };
  logic signed [DW-1:0] directed_k [NumDirected] = '{
    32'sd0, 32'sd0, 32'sd0, 32'sd7, -32'sd7, 32'sd7, -32'sd7, 32'sd1,
    -32'sd1, 32'sd1, -32'sd1, 32'sh8000_0000, 32'sh8000_0000,
    32'sh7fff_ffff, 32'sh7fff_ffff, 32'sd1134903170, 32'sd1134903170,
    -32'sd1836311903, 32'sd18, 32'sd18, -32'sd46, 32'sh2aaa_aaaa,
    32'sd3, 32'sd5
  };

  extended_euclid_bezout_unit #(
    .DATA_WIDTH(DW)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_value_n  (in_value_n),
    .in_value_k  (in_value_k),
    .out_valid   (out_valid),
    .out_divisor (out_divisor),
    .out_coef_n  (out_coef_n),
    .out_coef_k  (out_coef_k),
    .out_div_zero(out_div_zero)
  );

  extended_euclid_bezout_unit_checker #(
    .DATA_WIDTH(DW)
  ) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value_n   (in_value_n),
    .in_value_k   (in_value_k),
    .out_valid    (out_valid),
    .out_divisor  (out_divisor),
    .out_coef_n   (out_coef_n),
    .out_coef_k   (out_coef_k),
    .out_div_zero (out_div_zero),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .checked_count(checked_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int fib(input int idx);
    longint a;
    longint b;
    longint t;
    a = 0;
    b = 1;
    repeat (idx) begin
      t = a + b;
      a = b;
      b = t;
    end
    return int'(a);
  endfunction

  function automatic logic signed [DW-1:0] corner_operand();
    case ($urandom_range(0, 4))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic draw_operands(output logic signed [DW-1:0] n, output logic signed [DW-1:0] k);
    int pick;
    int g;
    int idx;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      n = $urandom;
      k = $urandom;
    end else if (pick < 60) begin
      n = $urandom_range(0, 200);
      k = $urandom_range(1, 200);
    end else if (pick < 75) begin
      g = $urandom_range(1, 65535);
      n = g * $urandom_range(0, 30000);
      k = g * $urandom_range(1, 30000);
    end else if (pick < 88) begin
      idx = $urandom_range(20, 45);
      n = fib(idx + 1);
      k = fib(idx);
    end else if (pick < 94) begin
      n = corner_operand();
      k = corner_operand();
    end else begin
      n = $urandom;
      k = '0;
    end
    if ($urandom_range(0, 1)) n = -n;
    if ($urandom_range(0, 1)) k = -k;
  endtask

  // start stays high on return; the caller lowers it for a gap
  task automatic issue(input logic signed [DW-1:0] n, input logic signed [DW-1:0] k);
    start      <= 1'b1;
    in_value_n <= n;
    in_value_k <= k;
    do @(posedge clk); while (busy);
    issued++;
    if (k == 0) zero_k_count++;
  endtask

  task automatic hold_off(input int n_cycles);
    start <= 1'b0;
    repeat (n_cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    logic signed [DW-1:0] n;
    logic signed [DW-1:0] k;
    int                   burst;
    int                   gap_sel;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_value_n = '0;
    in_value_k = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NumDirected; i++) begin
      issue(directed_n[i], directed_k[i]);
    end
    drain();

    while (issued < NumDirected + Items) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        draw_operands(n, k);
        issue(n, k);
      end
      gap_sel = $urandom_range(0, 3);
      if (gap_sel == 1 || gap_sel == 2) begin
        hold_off($urandom_range(1, 25));
      end else if (gap_sel == 3) begin
        hold_off($urandom_range(26, 1800));
      end
    end
    drain();
    repeat (2000) @(posedge clk);

    $display("tb: %0d transactions issued (%0d with k = 0), %0d results checked",
             issued, zero_k_count, checked_count);
    $display("tb: covered sign extremes, Fibonacci worst-case chains, shared factors, full range");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
